@@ src/vgm_pkg.sv @@
// Shared types, constants and the 14-segment font for the VFD grid multiplex controller.
`timescale 1ns / 1ps
package vgm_pkg;

  // Operation codes
  localparam logic [1:0] OP_REFRESH = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_SCROLL  = 2'd2;

  // Frame layout
  localparam int SEG_BITS    = 14;
  localparam int SELECT_BITS = 11;
  localparam int FRAME_BITS  = 30;
  localparam int CNT_W       = $clog2(FRAME_BITS);

  typedef logic [SEG_BITS-1:0] seg_t;

  // Segment positions
  localparam seg_t SG_A = seg_t'(1) << 0;
  localparam seg_t SG_B = seg_t'(1) << 1;
  localparam seg_t SG_F = seg_t'(1) << 2;
  localparam seg_t SG_K = seg_t'(1) << 3;
  localparam seg_t SG_J = seg_t'(1) << 4;
  localparam seg_t SG_H = seg_t'(1) << 5;
  localparam seg_t SG_M = seg_t'(1) << 6;
  localparam seg_t SG_G = seg_t'(1) << 7;
  localparam seg_t SG_N = seg_t'(1) << 8;
  localparam seg_t SG_P = seg_t'(1) << 9;
  localparam seg_t SG_R = seg_t'(1) << 10;
  localparam seg_t SG_C = seg_t'(1) << 11;
  localparam seg_t SG_E = seg_t'(1) << 12;
  localparam seg_t SG_D = seg_t'(1) << 13;

  // Controller to datapath commands
  typedef struct packed {
    logic load_frame;
    logic shift;
    logic advance;
    logic load_char;
    logic scroll_char;
  } vgm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_bit;
  } vgm_stat_t;

  function automatic seg_t font_pattern(input logic [7:0] ch);
    seg_t v;
    v = '0;
    case (ch)
      8'h30: v = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F | SG_K | SG_R;
      8'h31: v = SG_B | SG_C;
      8'h32: v = SG_A | SG_B | SG_D | SG_E | SG_G | SG_M;
      8'h33: v = SG_A | SG_B | SG_C | SG_D | SG_M;
      8'h34: v = SG_B | SG_C | SG_F | SG_G | SG_M;
      8'h35: v = SG_A | SG_C | SG_D | SG_F | SG_G | SG_M;
      8'h36: v = SG_A | SG_C | SG_D | SG_E | SG_F | SG_G | SG_M;
      8'h37: v = SG_A | SG_B | SG_C;
      8'h38: v = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F | SG_G | SG_M;
      8'h39: v = SG_A | SG_B | SG_C | SG_D | SG_F | SG_G | SG_M;
      8'h41: v = SG_A | SG_B | SG_C | SG_E | SG_F | SG_G | SG_M;
      8'h42: v = SG_A | SG_B | SG_C | SG_D | SG_J | SG_P | SG_M;
      8'h43: v = SG_A | SG_D | SG_E | SG_F;
      8'h44: v = SG_A | SG_B | SG_C | SG_D | SG_J | SG_P;
      8'h45: v = SG_A | SG_D | SG_E | SG_F | SG_G | SG_M;
      8'h46: v = SG_A | SG_E | SG_F | SG_G;
      8'h47: v = SG_A | SG_C | SG_D | SG_E | SG_F | SG_M;
      8'h48: v = SG_B | SG_C | SG_E | SG_F | SG_G | SG_M;
      8'h49: v = SG_J | SG_P;
      8'h4A: v = SG_B | SG_C | SG_D | SG_E;
      8'h4B: v = SG_E | SG_F | SG_G | SG_K | SG_N;
      8'h4C: v = SG_D | SG_E | SG_F;
      8'h4D: v = SG_B | SG_C | SG_E | SG_F | SG_H | SG_K;
      8'h4E: v = SG_B | SG_C | SG_E | SG_F | SG_H | SG_N;
      8'h4F: v = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F;
      8'h50: v = SG_A | SG_B | SG_E | SG_F | SG_G | SG_M;
      8'h51: v = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F | SG_N;
      8'h52: v = SG_A | SG_B | SG_E | SG_F | SG_G | SG_M | SG_N;
      8'h53: v = SG_A | SG_C | SG_D | SG_F | SG_G | SG_M;
      8'h54: v = SG_A | SG_J | SG_P;
      8'h55: v = SG_B | SG_C | SG_D | SG_E | SG_F;
      8'h56: v = SG_E | SG_F | SG_K | SG_R;
      8'h57: v = SG_B | SG_C | SG_E | SG_F | SG_N | SG_R;
      8'h58: v = SG_H | SG_K | SG_N | SG_R;
      8'h59: v = SG_H | SG_K | SG_P;
      8'h5A: v = SG_A | SG_D | SG_K | SG_R;
      8'h2B: v = SG_G | SG_J | SG_M | SG_P;
      8'h2D: v = SG_G | SG_M;
      8'h2A: v = SG_G | SG_H | SG_J | SG_K | SG_M | SG_N | SG_P | SG_R;
      8'h5F: v = SG_D;
      8'h2F: v = SG_K | SG_R;
      8'h2C: v = SG_R;
      8'h27: v = SG_J;
      8'h24: v = SG_A | SG_C | SG_D | SG_F | SG_G | SG_M | SG_J | SG_P;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ src/vgm_ctrl.sv @@
// Controller state machine: accepts transactions and sequences the frame shift.
`timescale 1ns / 1ps
module vgm_ctrl
  import vgm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] operation,
  input  vgm_stat_t  stat,
  output vgm_cmd_t   cmd,
  output logic       busy
);

  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } state_t;

  state_t state;
  logic   accept;

  assign accept = start && !busy;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.load_frame  = accept && (operation == OP_REFRESH);
        cmd.load_char   = accept && (operation == OP_LOAD);
        cmd.scroll_char = accept && (operation == OP_SCROLL);
      end
      ST_SHIFT: begin
        cmd.shift   = 1'b1;
        cmd.advance = stat.last_bit;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && operation == OP_REFRESH) begin
            state <= ST_SHIFT;
            busy  <= 1'b1;
          end
        end
        ST_SHIFT: begin
          if (stat.last_bit) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ src/vgm_datapath.sv @@
// Datapath: grid pattern registers, active grid, string state and frame shifter.
`timescale 1ns / 1ps
module vgm_datapath
  import vgm_pkg::*;
#(
  parameter int NUM_GRIDS = 11
) (
  input  logic       clk,
  input  logic       rst,
  input  vgm_cmd_t   cmd,
  input  logic [7:0] char_code,
  input  logic [3:0] char_index,
  output vgm_stat_t  stat,
  output logic       serial_bit
);

  localparam int GW = $clog2(NUM_GRIDS);

  seg_t                  grid [NUM_GRIDS];
  logic [GW-1:0]         active_grid;
  logic                  string_ended;
  logic [FRAME_BITS-1:0] frame_sr;
  logic [CNT_W-1:0]      bit_count;

  logic                   index_ok;
  logic                   ended_next;
  logic [GW-1:0]          load_addr;
  seg_t                   glyph;
  logic [SELECT_BITS-1:0] select;
  logic [FRAME_BITS-1:0]  frame;

  assign glyph     = font_pattern(char_code);
  assign index_ok  = int'(char_index) < NUM_GRIDS - 1;
  assign load_addr = GW'(NUM_GRIDS - 1 - int'(char_index));
  assign ended_next = (char_index == 4'd0) ? (char_code == 8'd0)
                                           : (string_ended || char_code == 8'd0);

  // One-hot select, blank past the eleventh position
  always_comb begin
    for (int i = 0; i < SELECT_BITS; i++) begin
      select[i] = (int'(active_grid) == i);
    end
  end

  assign frame = {3'b000, grid[active_grid], 2'b00, select};

  assign stat.last_bit = (bit_count == CNT_W'(FRAME_BITS - 1));
  assign serial_bit    = frame_sr[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_GRIDS; i++) begin
        grid[i] <= '0;
      end
      active_grid  <= '0;
      string_ended <= 1'b0;
    end else begin
      if (cmd.load_char && index_ok) begin
        string_ended     <= ended_next;
        grid[load_addr]  <= ended_next ? seg_t'(0) : glyph;
      end
      if (cmd.scroll_char) begin
        for (int i = NUM_GRIDS - 1; i > 1; i--) begin
          grid[i] <= grid[i-1];
        end
        grid[1] <= glyph;
      end
      if (cmd.advance) begin
        if (int'(active_grid) >= NUM_GRIDS - 1) begin
          active_grid <= '0;
        end else begin
          active_grid <= active_grid + GW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= '0;
    end else if (cmd.load_frame) begin
      bit_count <= '0;
    end else if (cmd.shift) begin
      bit_count <= bit_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      frame_sr <= frame;
    end else if (cmd.shift) begin
      frame_sr <= {1'b0, frame_sr[FRAME_BITS-1:1]};
    end
  end

endmodule

@@ src/vfd_grid_multiplex_controller.sv @@
// Top level of the 14-segment VFD grid multiplex controller.
`timescale 1ns / 1ps
// A transaction is accepted on a rising edge with start high and busy low.
// Load (operation 1) and scroll (operation 2) transactions update the grid
// registers at that edge and leave busy low, so one may follow every cycle.
// A refresh tick (operation 0) raises busy on the next cycle and then shifts
// out a 30-bit frame, one bit per clock: bit_strobe marks each bit on
// serial_bit, and strobe_after is high on the thirtieth. The frame is
// the one-hot grid select (position 0 first, 11 positions), two zero bits,
// the active grid's 14 segment bits LSB first, and three zero bits. Busy
// falls after the last bit, when the active grid advances modulo NUM_GRIDS,
// so a refresh tick holds busy until its whole frame is shifted out, and the
// next transaction is taken once busy is low again. The receiver cannot
// stall: every bit must be taken in the cycle it is shown. Grid 0 is never
// written and stays blank; a load index of NUM_GRIDS-1 or more and operation
// code 3 are ignored.
module vfd_grid_multiplex_controller
  import vgm_pkg::*;
#(
  parameter int NUM_GRIDS = 11
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation,
  input  logic [7:0] char_code,
  input  logic [3:0] char_index,
  output logic       bit_strobe,
  output logic       serial_bit,
  output logic       strobe_after
);

  vgm_cmd_t  cmd;
  vgm_stat_t stat;

  vgm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  vgm_datapath #(
    .NUM_GRIDS (NUM_GRIDS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .char_code  (char_code),
    .char_index (char_index),
    .stat       (stat),
    .serial_bit (serial_bit)
  );

  // The controller is busy exactly while frame bits are on the wire.
  assign bit_strobe   = cmd.shift;
  assign strobe_after = cmd.shift && stat.last_bit;

endmodule

@@ src/vgm_checker.sv @@
// Port-level checker for the VFD grid multiplex controller, with its bind.
`timescale 1ns / 1ps
module vgm_checker
  import vgm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] operation,
  input logic       bit_strobe,
  input logic       strobe_after
);

  // Latch strobe only on a frame bit
  a_strobe_in_frame: assert property (@(posedge clk) disable iff (rst)
    strobe_after |-> bit_strobe)
    else $error("strobe_after outside a frame");

  // A frame runs without gaps until its last bit
  a_frame_contiguous: assert property (@(posedge clk) disable iff (rst)
    (bit_strobe && !strobe_after) |=> bit_strobe)
    else $error("frame ended before its last bit");

  // The last bit closes the frame
  a_frame_closes: assert property (@(posedge clk) disable iff (rst)
    strobe_after |=> !bit_strobe)
    else $error("frame continued past its last bit");

  // A frame starts only after an accepted refresh tick
  a_frame_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(bit_strobe) |-> $past(start && !busy && operation == OP_REFRESH))
    else $error("frame without a refresh transaction");

endmodule

bind vfd_grid_multiplex_controller vgm_checker u_vgm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .operation    (operation),
  .bit_strobe   (bit_strobe),
  .strobe_after (strobe_after)
);

@@ verif/tb.sv @@
// Self-checking testbench for the VFD grid multiplex controller: frame bits vs. a shadow display.
`timescale 1ns / 1ps

class display_scoreboard;
  localparam int GRIDS = 11;
  localparam int FRAME_LEN = 30;
  localparam int SEL_LEN = 11;
  localparam int SEG_LEN = 14;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic data;
    logic last;
  } frame_bit_t;

  vgm_pkg::seg_t grid_seg[GRIDS];
  int unsigned   scan_grid;
  bit            text_closed;
  frame_bit_t    pending_bits[$];

  int unsigned n_refresh, n_load, n_scroll, n_ignored, bits_checked;
  int unsigned mismatches, unexpected;

  function new();
    foreach (grid_seg[i]) grid_seg[i] = '0;
    scan_grid   = 0;
    text_closed = 1'b0;
  endfunction

  // Shadow font: digits, upper case and a handful of symbols, blank otherwise.
  function vgm_pkg::seg_t glyph_of(input logic [7:0] ch);
    import vgm_pkg::*;
    seg_t s;
    case (ch)
      "0": s = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F | SG_K | SG_R;
      "1": s = SG_B | SG_C;
      "2": s = SG_A | SG_B | SG_D | SG_E | SG_G | SG_M;
      "3": s = SG_A | SG_B | SG_C | SG_D | SG_M;
      "4": s = SG_B | SG_C | SG_F | SG_G | SG_M;
      "5": s = SG_A | SG_C | SG_D | SG_F | SG_G | SG_M;
      "6": s = SG_A | SG_C | SG_D | SG_E | SG_F | SG_G | SG_M;
      "7": s = SG_A | SG_B | SG_C;
      "8": s = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F | SG_G | SG_M;
      "9": s = SG_A | SG_B | SG_C | SG_D | SG_F | SG_G | SG_M;
      "A": s = SG_A | SG_B | SG_C | SG_E | SG_F | SG_G | SG_M;
      "B": s = SG_A | SG_B | SG_C | SG_D | SG_J | SG_P | SG_M;
      "C": s = SG_A | SG_D | SG_E | SG_F;
      "D": s = SG_A | SG_B | SG_C | SG_D | SG_J | SG_P;
      "E": s = SG_A | SG_D | SG_E | SG_F | SG_G | SG_M;
      "F": s = SG_A | SG_E | SG_F | SG_G;
      "G": s = SG_A | SG_C | SG_D | SG_E | SG_F | SG_M;
      "H": s = SG_B | SG_C | SG_E | SG_F | SG_G | SG_M;
      "I": s = SG_J | SG_P;
      "J": s = SG_B | SG_C | SG_D | SG_E;
      "K": s = SG_E | SG_F | SG_G | SG_K | SG_N;
      "L": s = SG_D | SG_E | SG_F;
      "M": s = SG_B | SG_C | SG_E | SG_F | SG_H | SG_K;
      "N": s = SG_B | SG_C | SG_E | SG_F | SG_H | SG_N;
      "O": s = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F;
      "P": s = SG_A | SG_B | SG_E | SG_F | SG_G | SG_M;
      "Q": s = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F | SG_N;
      "R": s = SG_A | SG_B | SG_E | SG_F | SG_G | SG_M | SG_N;
      "S": s = SG_A | SG_C | SG_D | SG_F | SG_G | SG_M;
      "T": s = SG_A | SG_J | SG_P;
      "U": s = SG_B | SG_C | SG_D | SG_E | SG_F;
      "V": s = SG_E | SG_F | SG_K | SG_R;
      "W": s = SG_B | SG_C | SG_E | SG_F | SG_N | SG_R;
      "X": s = SG_H | SG_K | SG_N | SG_R;
      "Y": s = SG_H | SG_K | SG_P;
      "Z": s = SG_A | SG_D | SG_K | SG_R;
      "+": s = SG_G | SG_J | SG_M | SG_P;
      "-": s = SG_G | SG_M;
      "*": s = SG_G | SG_H | SG_J | SG_K | SG_M | SG_N | SG_P | SG_R;
      "_": s = SG_D;
      "/": s = SG_K | SG_R;
      ",": s = SG_R;
      "'": s = SG_J;
      "$": s = SG_A | SG_C | SG_D | SG_F | SG_G | SG_M | SG_J | SG_P;
      default: s = '0;
    endcase
    return s;
  endfunction

  // Accepted transaction: update the shadow display, queue frame bits on a refresh.
  function void note_transaction(input logic [1:0] op, input logic [7:0] ch,
                                 input logic [3:0] idx);
    frame_bit_t fb;
    case (op)
      vgm_pkg::OP_REFRESH: begin
        n_refresh++;
        for (int pos = 0; pos < FRAME_LEN; pos++) begin
          fb.data = 1'b0;
          if (pos < SEL_LEN)
            fb.data = (pos == scan_grid);
          else if (pos >= SEL_LEN + 2 && pos < SEL_LEN + 2 + SEG_LEN)
            fb.data = grid_seg[scan_grid][pos - SEL_LEN - 2];
          fb.last = (pos == FRAME_LEN - 1);
          pending_bits.push_back(fb);
        end
        scan_grid = (scan_grid >= GRIDS - 1) ? 0 : scan_grid + 1;
      end
      vgm_pkg::OP_LOAD: begin
        if (idx >= GRIDS - 1) begin
          n_ignored++;
        end else begin
          n_load++;
          if (idx == 0)
            text_closed = (ch == 8'd0);
          else if (ch == 8'd0)
            text_closed = 1'b1;
          grid_seg[GRIDS - 1 - idx] = text_closed ? '0 : glyph_of(ch);
        end
      end
      vgm_pkg::OP_SCROLL: begin
        n_scroll++;
        for (int g = GRIDS - 1; g > 1; g--) grid_seg[g] = grid_seg[g - 1];
        grid_seg[1] = glyph_of(ch);
      end
      default: n_ignored++;
    endcase
  endfunction

  function void check_bit(input logic data, input logic last);
    frame_bit_t want;
    if (pending_bits.size() == 0) begin
      unexpected++;
      if (mismatches + unexpected <= REPORT_MAX)
        $display("[%0t] unexpected frame bit: serial_bit=%b strobe_after=%b",
                 $realtime, data, last);
      return;
    end
    want = pending_bits.pop_front();
    bits_checked++;
    if (data !== want.data || last !== want.last) begin
      mismatches++;
      if (mismatches + unexpected <= REPORT_MAX)
        $display("[%0t] frame bit mismatch: exp serial_bit=%b strobe_after=%b, got %b %b",
                 $realtime, want.data, want.last, data, last);
    end
  endfunction

  function int unsigned outstanding();
    return pending_bits.size();
  endfunction

  function int unsigned failures();
    return mismatches + unexpected + pending_bits.size();
  endfunction
endclass

module tb;
  import vgm_pkg::*;

  localparam int GRIDS = 11;
  localparam int LIMIT = 200000;           // far above the slowest legal run
  localparam int DRAIN_CYCLES = 40;        // more than one frame
  localparam int RANDOM_ITEMS = 160;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Characters with a glyph; random strings are drawn mostly from these.
  localparam string GLYPH_CHARS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ+-*_/,'$";

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] operation = OP_REFRESH;
  logic [7:0] char_code = 8'd0;
  logic [3:0] char_index = 4'd0;
  logic       busy;
  logic       bit_strobe;
  logic       serial_bit;
  logic       strobe_after;

  display_scoreboard sb;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned live_items = 0;   // transactions the block actually acts on

  vfd_grid_multiplex_controller #(.NUM_GRIDS(GRIDS)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .char_code    (char_code),
    .char_index   (char_index),
    .bit_strobe   (bit_strobe),
    .serial_bit   (serial_bit),
    .strobe_after (strobe_after)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor. Values read here are the ones settled before the edge, so the
  // DUT's own updates at this edge never leak in. A frame bit is checked
  // before any transaction taken at the same edge is noted.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (bit_strobe)
        sb.check_bit(serial_bit, strobe_after);
      if (start && !busy)
        sb.note_transaction(operation, char_code, char_index);
    end
  end

  // Watchdog: a hung handshake or a frame that never ends.
  initial begin
    wait (cycle_count >= LIMIT);
    $display("timeout after %0d cycles, %0d frame bits still pending",
             cycle_count, sb.outstanding());
    $display("Regression FAIL");
    $finish;
  end

  // Present one transaction and hold it until the edge that takes it.
  // start is left high so a following call keeps it asserted back to back.
  task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                           input logic [3:0] idx);
    start      <= 1'b1;
    operation  <= op;
    char_code  <= ch;
    char_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op != OP_UNUSED && !(op == OP_LOAD && idx >= GRIDS - 1))
      live_items++;
  endtask

  // Sender pacing: bursts of random length, random idle gaps between them.
  // Long bursts now and then give stretches with no idling at all.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 35)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 10);
    end
  endtask

  // Stop sending and let every queued frame bit come out.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75)
      return GLYPH_CHARS[$urandom_range(0, GLYPH_CHARS.len() - 1)];
    else if (r < 82)
      return 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned kind, len;
    bit          drained_mid;

    sb = new();
    drained_mid = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // ---- Directed part ----
    send_item(OP_REFRESH, 8'd0, 4'd0);        // blank grid 0 straight out of reset
    send_item(OP_LOAD, "A", 4'd0);            // lowest index -> top grid
    send_item(OP_LOAD, "8", 4'd9);            // highest legal index -> grid 1
    send_item(OP_LOAD, "*", 4'd1);
    send_item(OP_LOAD, "B", 4'd10);           // index too large: dropped
    send_item(OP_LOAD, 8'hFF, 4'd15);         // all-ones index and code: dropped
    send_item(OP_UNUSED, 8'hFF, 4'd15);       // spare opcode: no effect
    send_item(OP_LOAD, 8'd0, 4'd2);           // terminator mid-string
    send_item(OP_LOAD, "Z", 4'd3);            // after terminator: stays blank
    send_item(OP_LOAD, 8'd0, 4'd0);           // zero at index 0: new, already ended
    send_item(OP_LOAD, "1", 4'd1);            // still blank
    send_item(OP_LOAD, "$", 4'd0);            // fresh string reopens
    send_item(OP_SCROLL, "_", 4'd0);
    send_item(OP_SCROLL, "a", 4'hF);          // lower case has no glyph
    // Eleven ticks walk the scan through every grid and past the wrap.
    for (int k = 0; k < 11; k++) send_item(OP_REFRESH, 8'hFF, 4'hF);
    drain();

    // ---- Random part ----
    // Mostly well-formed strings, scrolls and refresh runs with random
    // content; the rest is noise with any opcode, code and index.
    burst_left = $urandom_range(0, 10);
    while (live_items < RANDOM_ITEMS + 25) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
          send_item(OP_LOAD, pick_char(), 4'(k));
          pace();
        end
      end else if (kind < 5) begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          send_item(OP_SCROLL, pick_char(), 4'($urandom_range(0, 15)));
          pace();
        end
      end else if (kind < 8) begin
        len = $urandom_range(1, 12);
        repeat (len) begin
          send_item(OP_REFRESH, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
          pace();
        end
      end else begin
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  4'($urandom_range(0, 15)));
        pace();
      end
      // Once, midway, hold off until the display has caught up completely.
      if (!drained_mid && live_items > 25 + RANDOM_ITEMS / 2) begin
        drained_mid = 1'b1;
        drain();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d refresh ticks, %0d loads, %0d scrolls, %0d ignored transactions",
             sb.n_refresh, sb.n_load, sb.n_scroll, sb.n_ignored);
    $display("%0d frame bits compared, %0d mismatched, %0d unexpected, %0d missing",
             sb.bits_checked, sb.mismatches, sb.unexpected, sb.outstanding());
    if (sb.failures() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

@@ files.f @@
src/vgm_pkg.sv
src/vgm_ctrl.sv
src/vgm_datapath.sv
src/vfd_grid_multiplex_controller.sv
src/vgm_checker.sv
verif/tb.sv
